@@ hdl/pst_pkg.sv @@
// Shared types and constants for the profile statistics table.
// No dependencies; every other file imports this package.
package pst_pkg;
	localparam int TABLE_DEPTH   = 1024;
	localparam int IDX_W         = $clog2(TABLE_DEPTH);
	localparam int FILL_W        = IDX_W + 1;
	localparam int NAME_ID_WIDTH = 16;
	localparam int DATA_W        = 64;
	localparam int DIV_CNT_W     = $clog2(DATA_W) + 1;

	localparam logic [DATA_W-1:0] TIME_ALL_ONES = '1;

	typedef enum logic [0:0] {
		ACT_RECORD = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_NEW     = 2'd1,
		ST_FULL    = 2'd2,
		ST_CLEARED = 2'd3
	} status_t;

	typedef struct packed {
		logic [0:0]               action;
		logic [NAME_ID_WIDTH-1:0] name_id;
		logic [DATA_W-1:0]        address;
		logic [DATA_W-1:0]        exec_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  entry_index;
		logic [DATA_W-1:0] calls;
		logic [DATA_W-1:0] time_sum;
		logic [DATA_W-1:0] time_low;
		logic [DATA_W-1:0] time_high;
		logic [DATA_W-1:0] time_mean;
	} out_item_t;

	typedef struct packed {
		logic [NAME_ID_WIDTH-1:0] name_id;
		logic [DATA_W-1:0]        address;
	} key_t;

	typedef struct packed {
		logic [DATA_W-1:0] total;
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] min;
		logic [DATA_W-1:0] max;
	} stats_t;
endpackage

@@ hdl/pst_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on pst_pkg.
interface pst_in_if;
	import pst_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pst_out_if;
	import pst_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/pst_front.sv @@
// Front end: takes input transfers into a two-entry queue for the back end.
// Depends on pst_pkg and pst_if.
module pst_front (
	input  logic  clk,
	input  logic  arst_n,
	pst_in_if.sink   sample,
	pst_in_if.source queued
);
	import pst_pkg::*;

	in_item_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] used_q;
	logic       push;
	logic       pop;

	assign sample.ready   = (used_q != 2'd2);
	assign push           = sample.valid && sample.ready;
	assign queued.valid   = (used_q != 2'd0);
	assign queued.payload = slot_q[rd_ptr_q];
	assign pop            = queued.valid && queued.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= sample.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) used_q <= used_q + 2'd1;
			else if (pop && !push) used_q <= used_q - 2'd1;
		end
	end
endmodule

@@ hdl/pst_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on pst_pkg.
module pst_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pst_pkg::DATA_W-1:0] dividend,
	input  logic [pst_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [pst_pkg::DATA_W-1:0] quotient
);
	import pst_pkg::*;

	logic [DATA_W-1:0]    dvd_q;
	logic [DATA_W-1:0]    dvs_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 take;

	assign trial    = {rem_q, dvd_q[DATA_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign take     = (trial >= {1'b0, dvs_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift quotient bits in where dividend bits leave
			dvd_q <= {dvd_q[DATA_W-2:0], take};
			rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ hdl/pst_back.sv @@
// Back end: searches the key memory, updates the statistics memory,
// divides for the average and holds the result. Depends on pst_pkg, pst_if, pst_div.
module pst_back (
	input  logic  clk,
	input  logic  arst_n,
	pst_in_if.sink    queued,
	pst_out_if.source result
);
	import pst_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_LOAD   = 6'b000100,
		S_UPD    = 6'b001000,
		S_DIV    = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t            state_q;
	in_item_t          item_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] issue_q;
	logic              cmp_valid_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic [IDX_W-1:0]  hit_q;
	logic [1:0]        status_q;
	stats_t            base_q;
	stats_t            new_q;
	logic [DATA_W-1:0] avg_q;
	logic              out_valid_q;
	out_item_t         out_q;

	key_t   key_mem [TABLE_DEPTH];
	stats_t stats_mem [TABLE_DEPTH];
	key_t   key_rd_q;
	stats_t stats_rd_q;

	logic   issue_more;
	logic   match;
	logic   key_we;
	logic   stats_we;
	stats_t upd;
	logic   div_start;
	logic   div_done;
	logic [DATA_W-1:0] div_quot;
	logic   out_free;

	assign issue_more = (issue_q < fill_q);
	assign match = cmp_valid_q && ((key_rd_q.address == item_q.address)
		|| (key_rd_q.name_id == item_q.name_id));
	assign queued.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	always_comb begin
		upd.total = base_q.total + item_q.exec_time;
		upd.count = base_q.count + DATA_W'(1);
		upd.min   = (item_q.exec_time < base_q.min) ? item_q.exec_time : base_q.min;
		upd.max   = (item_q.exec_time > base_q.max) ? item_q.exec_time : base_q.max;
	end

	assign key_we    = (state_q == S_SEARCH) && !match && !issue_more && !cmp_valid_q
		&& (fill_q != FILL_W'(TABLE_DEPTH));
	assign stats_we  = (state_q == S_UPD);
	assign div_start = stats_we;

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[fill_q[IDX_W-1:0]] <= '{name_id: item_q.name_id, address: item_q.address};
		end
		key_rd_q <= key_mem[issue_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (stats_we) begin
			stats_mem[hit_q] <= upd;
		end
		stats_rd_q <= stats_mem[cmp_idx_q];
	end

	pst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (upd.total),
		.divisor  (upd.count),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (queued.valid) item_q <= queued.payload;
				issue_q <= '0;
			end
			S_SEARCH: begin
				if (issue_more) issue_q <= issue_q + 1'b1;
				// hold the index on a match so the hit entry's statistics are read
				if (!match) cmp_idx_q <= issue_q[IDX_W-1:0];
				if (match) begin
					hit_q    <= cmp_idx_q;
					status_q <= ST_UPDATED;
				end else if (!issue_more && !cmp_valid_q) begin
					hit_q    <= fill_q[IDX_W-1:0];
					base_q   <= '{total: '0, count: '0, min: TIME_ALL_ONES, max: '0};
					status_q <= (fill_q == FILL_W'(TABLE_DEPTH)) ? ST_FULL : ST_NEW;
					avg_q    <= '0;
				end
			end
			S_LOAD: base_q <= stats_rd_q;
			S_UPD: new_q <= upd;
			S_DIV: begin
				if (div_done) avg_q <= (new_q.count == '0) ? '0 : div_quot;
			end
			S_OUT: ;
			default: ;
		endcase
		if (state_q == S_OUT && out_free) begin
			if (status_q == ST_FULL || status_q == ST_CLEARED) begin
				out_q <= '{status: status_q, entry_index: '0, calls: '0,
					time_sum: '0, time_low: '0, time_high: '0, time_mean: '0};
			end else begin
				out_q <= '{status: status_q, entry_index: hit_q, calls: new_q.count,
					time_sum: new_q.total, time_low: new_q.min, time_high: new_q.max,
					time_mean: avg_q};
			end
		end
		if (state_q == S_IDLE && queued.valid && queued.payload.action == ACT_CLEAR) begin
			status_q <= ST_CLEARED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cmp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cmp_valid_q <= 1'b0;
					if (queued.valid) begin
						if (queued.payload.action == ACT_CLEAR) begin
							fill_q  <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					cmp_valid_q <= issue_more && !match;
					if (match) begin
						state_q <= S_LOAD;
					end else if (!issue_more && !cmp_valid_q) begin
						if (fill_q == FILL_W'(TABLE_DEPTH)) begin
							state_q <= S_OUT;
						end else begin
							fill_q  <= fill_q + 1'b1;
							state_q <= S_UPD;
						end
					end
				end
				S_LOAD: state_q <= S_UPD;
				S_UPD: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/profile_statistics_table.sv @@
// Top level of the profile statistics table.
// Depends on pst_pkg, pst_if, pst_front and pst_back.
//
// Input items arrive on the sample channel, results leave on the result
// channel; both are valid/ready, a transfer taking place when both are high.
// A record item searches the table in fill order for an entry with the same
// address or name id, appends one on a miss, updates count, total, min and
// max and returns them with the truncated average. A clear item empties the
// table at once and returns the cleared status.
// The front end queues up to two items, so the sender is held only when two
// are waiting. A record item passes from its input transfer to its result
// through the key memory search, one table entry at a time behind the read
// pipeline, then the statistics memory read and write, and then the
// bit-serial divider. A clear skips the search and the divider; a sample
// dropped on a full table needs the whole search.
// One item is worked on at a time; the next is taken once the result is loaded.
// Reset empties the table and the queue and drops a pending result.
// If the receiver stalls, the result is held in the output register and the
// back end waits with its next result until that one is taken.
module profile_statistics_table (
	input  logic clk,
	input  logic arst_n,
	pst_in_if.sink    sample,
	pst_out_if.source result
);
	import pst_pkg::*;

	pst_in_if queued ();

	pst_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.queued (queued)
	);

	pst_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.queued (queued),
		.result (result)
	);
endmodule
